@@ rtl/assert_macros.svh @@
// ----------------------------------------------------------------------------
// assert_macros.svh
// Concurrent assertion helpers used by the checker file lkvl_checker
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, disabled while reset is asserted
`define ASSERT_IMPLY(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("assertion failed");

// next-cycle implication, disabled while reset is asserted
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("assertion failed");

`endif

@@ rtl/lkvl_pkg.sv @@
// ----------------------------------------------------------------------------
// lkvl_pkg
// Types and constants of the looping keyframe vector interpolator
// ----------------------------------------------------------------------------
package lkvl_pkg;

	localparam int unsigned CFG_IDX_W = 2;
	localparam logic [CFG_IDX_W-1:0] CFG_CLIP_LENGTH = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_KEY_COUNT   = 2'd1;

	localparam logic FUNC_WRITE  = 1'b0;
	localparam logic FUNC_SAMPLE = 1'b1;

	localparam int unsigned DIV_STEPS = 16;
	localparam logic [16:0] ONE_Q16 = 17'h10000;

	// input item
	typedef struct packed {
		logic               func;
		logic [5:0]         key_index;
		logic [31:0]        key_time;
		logic signed [31:0] key_x;
		logic signed [31:0] key_y;
		logic signed [31:0] key_z;
		logic [31:0]        play_time;
	} req_t;

	// result item
	typedef struct packed {
		logic signed [31:0] value_x;
		logic signed [31:0] value_y;
		logic signed [31:0] value_z;
		logic [16:0]        blend_frac;
		logic               status;
	} rsp_t;

	typedef enum logic [1:0] {
		RD_MID,
		RD_START,
		RD_END
	} rd_sel_t;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_SRCH_RD,
		ST_SRCH_CMP,
		ST_RD_S,
		ST_RD_E,
		ST_LD_END,
		ST_SPAN,
		ST_PREP,
		ST_DIV,
		ST_MUL,
		ST_FIN
	} state_t;

	// controller to datapath
	typedef struct packed {
		logic       wr_key;
		logic       take_sample;
		rd_sel_t    rd_sel;
		logic       srch_step;
		logic       ld_start;
		logic       ld_end;
		logic       calc_span;
		logic       prep;
		logic       div_step;
		logic       mul_en;
		logic [1:0] mul_idx;
		logic       acc_en;
		logic [1:0] acc_idx;
		logic       out_load;
	} cmd_t;

	// datapath to controller
	typedef struct packed {
		logic srch_done;
		logic need_div;
		logic out_full;
	} sts_t;

endpackage

@@ rtl/lkvl_ctrl.sv @@
// ----------------------------------------------------------------------------
// lkvl_ctrl
// Sequencer: search, key fetch, span, division and blend steps
// ----------------------------------------------------------------------------
module lkvl_ctrl import lkvl_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  logic req_valid,
	input  logic req_func,
	output logic req_stall,
	input  sts_t sts,
	output cmd_t cmd
);

	state_t     state_q, state_d;
	logic [4:0] cnt_q, cnt_d;

	// state and step counter
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			cnt_q   <= '0;
		end else begin
			state_q <= state_d;
			cnt_q   <= cnt_d;
		end
	end

	// next state and commands
	always_comb begin
		state_d   = state_q;
		cnt_d     = cnt_q;
		cmd       = '0;
		cmd.rd_sel = RD_MID;
		req_stall = 1'b1;
		unique case (state_q)
			ST_IDLE: begin
				req_stall = 1'b0;
				if (req_valid) begin
					if (req_func == FUNC_WRITE) begin
						cmd.wr_key = 1'b1;
					end else begin
						cmd.take_sample = 1'b1;
						state_d = ST_SRCH_RD;
					end
				end
			end
			ST_SRCH_RD: begin
				cmd.rd_sel = RD_MID;
				if (sts.srch_done) state_d = ST_RD_S;
				else state_d = ST_SRCH_CMP;
			end
			ST_SRCH_CMP: begin
				cmd.srch_step = 1'b1;
				state_d = ST_SRCH_RD;
			end
			ST_RD_S: begin
				cmd.rd_sel = RD_START;
				state_d = ST_RD_E;
			end
			ST_RD_E: begin
				cmd.ld_start = 1'b1;
				cmd.rd_sel = RD_END;
				state_d = ST_LD_END;
			end
			ST_LD_END: begin
				cmd.ld_end = 1'b1;
				state_d = ST_SPAN;
			end
			ST_SPAN: begin
				cmd.calc_span = 1'b1;
				state_d = ST_PREP;
			end
			ST_PREP: begin
				cmd.prep = 1'b1;
				cnt_d = '0;
				if (sts.need_div) state_d = ST_DIV;
				else state_d = ST_MUL;
			end
			ST_DIV: begin
				cmd.div_step = 1'b1;
				if (cnt_q == 5'(DIV_STEPS - 1)) begin
					cnt_d = '0;
					state_d = ST_MUL;
				end else begin
					cnt_d = cnt_q + 5'd1;
				end
			end
			ST_MUL: begin
				// product of one component, sum of the previous one
				cmd.mul_en  = (cnt_q != 5'd3);
				cmd.mul_idx = cnt_q[1:0];
				cmd.acc_en  = (cnt_q != 5'd0);
				cmd.acc_idx = cnt_q[1:0] - 2'd1;
				if (cnt_q == 5'd3) begin
					cnt_d = '0;
					state_d = ST_FIN;
				end else begin
					cnt_d = cnt_q + 5'd1;
				end
			end
			ST_FIN: begin
				if (!sts.out_full) begin
					cmd.out_load = 1'b1;
					state_d = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

endmodule

@@ rtl/lkvl_dp.sv @@
// ----------------------------------------------------------------------------
// lkvl_dp
// Key table, search registers, span, divider, blend multiplier, result
// ----------------------------------------------------------------------------
module lkvl_dp import lkvl_pkg::*; #(
	parameter int unsigned MAX_KEYS = 64
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  req_t                 req,
	input  logic                 cfg_valid,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [31:0]          cfg_data,
	input  logic                 rsp_stall,
	output logic                 rsp_valid,
	output rsp_t                 rsp,
	input  cmd_t                 cmd,
	output sts_t                 sts
);

	localparam int unsigned IW = $clog2(MAX_KEYS);
	localparam int unsigned CW = $clog2(MAX_KEYS + 1);
	localparam int unsigned NW = (CW > 7) ? CW : 7;

	// configuration registers
	logic [31:0] clip_q;
	logic [6:0]  key_count_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clip_q      <= '0;
			key_count_q <= 7'd1;
		end else if (cfg_valid) begin
			if (cfg_index == CFG_CLIP_LENGTH) clip_q <= cfg_data;
			if (cfg_index == CFG_KEY_COUNT) key_count_q <= cfg_data[6:0];
		end
	end

	// key table: time above the three components
	logic [127:0] mem [MAX_KEYS];
	logic [127:0] rd_data_q;
	logic [IW-1:0] rd_addr;

	always_ff @(posedge clk) begin
		if (cmd.wr_key && (32'(req.key_index) < MAX_KEYS))
			mem[IW'(req.key_index)] <= {req.key_time, req.key_x, req.key_y, req.key_z};
		rd_data_q <= mem[rd_addr];
	end

	// search state
	logic [31:0]   play_q;
	logic [CW-1:0] n_q, lo_q, len_q;
	logic [CW-1:0] half, mid, si, ei;
	logic [NW-1:0] kc_ext;
	logic          wrap, le_play;

	assign kc_ext  = NW'(key_count_q);
	assign half    = len_q >> 1;
	assign mid     = lo_q + half;
	assign le_play = (rd_data_q[127:96] <= play_q);
	assign wrap    = (lo_q == '0) || (lo_q >= n_q);
	assign si      = wrap ? (n_q - CW'(1)) : (lo_q - CW'(1));
	assign ei      = wrap ? '0 : lo_q;

	always_comb begin
		unique case (cmd.rd_sel)
			RD_MID:   rd_addr = mid[IW-1:0];
			RD_START: rd_addr = si[IW-1:0];
			RD_END:   rd_addr = ei[IW-1:0];
			default:  rd_addr = mid[IW-1:0];
		endcase
	end

	always_ff @(posedge clk) begin
		if (cmd.take_sample) begin
			play_q <= req.play_time;
			lo_q   <= '0;
			if (kc_ext == '0) begin
				n_q   <= CW'(1);
				len_q <= CW'(1);
			end else if (kc_ext > NW'(MAX_KEYS)) begin
				n_q   <= CW'(MAX_KEYS);
				len_q <= CW'(MAX_KEYS);
			end else begin
				n_q   <= CW'(kc_ext);
				len_q <= CW'(kc_ext);
			end
		end else if (cmd.srch_step) begin
			if (le_play) begin
				lo_q  <= mid + CW'(1);
				len_q <= len_q - half - CW'(1);
			end else begin
				len_q <= half;
			end
		end
	end

	// start and end keys
	logic [127:0] start_q, end_q;

	always_ff @(posedge clk) begin
		if (cmd.ld_start) start_q <= rd_data_q;
		if (cmd.ld_end) end_q <= rd_data_q;
	end

	// span and target, wide enough that nothing wraps
	logic signed [34:0] ts, te, tp, clip, head;
	logic signed [34:0] span_q, target_q;

	assign ts   = $signed({3'b000, start_q[127:96]});
	assign te   = $signed({3'b000, end_q[127:96]});
	assign tp   = $signed({3'b000, play_q});
	assign clip = $signed({3'b000, clip_q});
	assign head = clip - ts;

	always_ff @(posedge clk) begin
		if (cmd.calc_span) begin
			if (te < ts) begin
				span_q   <= head + te;
				target_q <= (tp < te) ? (head + tp) : (tp - ts);
			end else begin
				span_q   <= te - ts;
				target_q <= tp - ts;
			end
		end
	end

	logic span_le0, tgt_le0, tgt_ge;
	assign span_le0 = span_q[34] || (span_q == '0);
	assign tgt_le0  = target_q[34] || (target_q == '0);
	assign tgt_ge   = (target_q >= span_q);
	assign sts.need_div = !span_le0 && !tgt_le0 && !tgt_ge;

	// restoring divider, one quotient bit a step
	logic [34:0] rem_q, rem2;
	logic [16:0] frac_q;
	logic        status_q, qbit;

	assign rem2 = {rem_q[33:0], 1'b0};
	assign qbit = (rem2 >= span_q[34:0]);

	always_ff @(posedge clk) begin
		if (cmd.prep) begin
			rem_q    <= target_q;
			status_q <= span_le0;
			if (span_le0 || tgt_le0) frac_q <= '0;
			else if (tgt_ge) frac_q <= ONE_Q16;
			else frac_q <= '0;
		end else if (cmd.div_step) begin
			rem_q  <= qbit ? (rem2 - span_q[34:0]) : rem2;
			frac_q <= {frac_q[15:0], qbit};
		end
	end

	// blend: one component per cycle, product registered before the add
	logic signed [31:0] a_sel, b_sel, a_acc;
	logic signed [32:0] diff;
	logic signed [50:0] prod_s1;
	logic signed [34:0] sum;
	logic [95:0]        val_q;

	always_comb begin
		unique case (cmd.mul_idx)
			2'd0:    begin a_sel = start_q[95:64]; b_sel = end_q[95:64]; end
			2'd1:    begin a_sel = start_q[63:32]; b_sel = end_q[63:32]; end
			default: begin a_sel = start_q[31:0];  b_sel = end_q[31:0];  end
		endcase
		unique case (cmd.acc_idx)
			2'd0:    a_acc = start_q[95:64];
			2'd1:    a_acc = start_q[63:32];
			default: a_acc = start_q[31:0];
		endcase
	end

	assign diff = 33'(b_sel) - 33'(a_sel);
	assign sum  = 35'(a_acc) + 35'(prod_s1 >>> 16);

	always_ff @(posedge clk) begin
		if (cmd.mul_en) prod_s1 <= 51'(diff * $signed({1'b0, frac_q}));
		if (cmd.acc_en) begin
			unique case (cmd.acc_idx)
				2'd0:    val_q[95:64] <= sum[31:0];
				2'd1:    val_q[63:32] <= sum[31:0];
				default: val_q[31:0]  <= sum[31:0];
			endcase
		end
	end

	// result register
	logic rsp_valid_q;
	rsp_t rsp_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) rsp_valid_q <= 1'b0;
		else if (cmd.out_load) rsp_valid_q <= 1'b1;
		else if (!rsp_stall) rsp_valid_q <= 1'b0;
	end

	always_ff @(posedge clk) begin
		if (cmd.out_load) begin
			rsp_q.value_x    <= val_q[95:64];
			rsp_q.value_y    <= val_q[63:32];
			rsp_q.value_z    <= val_q[31:0];
			rsp_q.blend_frac <= frac_q;
			rsp_q.status     <= status_q;
		end
	end

	assign rsp_valid     = rsp_valid_q;
	assign rsp           = rsp_q;
	assign sts.srch_done = (len_q == '0);
	assign sts.out_full  = rsp_valid_q && rsp_stall;

endmodule

@@ rtl/looping_keyframe_vector_lerp_top.sv @@
// ----------------------------------------------------------------------------
// looping_keyframe_vector_lerp_top
// Looping keyframe table with linear vector interpolation
// ----------------------------------------------------------------------------
// Usage:
//  req channel (req_valid/req_stall): func 0 writes a keyframe into slot
//   key_index, no result. func 1 samples the clip at play_time
//   and yields one result on the rsp channel (rsp_valid/rsp_stall).
//  cfg channel (cfg_valid/cfg_ready, always ready): index 0 clip_length,
//   index 1 key_count; other indexes are dropped. Write only when idle.
//  a sample runs a binary search (one table read port, read then compare),
//   then key fetch, span, a 16-step divider and three sequential multiplies;
//   the divider is skipped when the fraction is zero or one or the span is bad.
//  req_stall is high while a sample is in flight; the next item is taken
//   the cycle after the result is loaded.
//  a stalled result holds in the output register; a finished sample waits
//   only if that register is still occupied.
//  reset clears the registers to clip_length 0, key_count 1 and drops any
//   pending result; the key table is undefined until written.
// ----------------------------------------------------------------------------
module looping_keyframe_vector_lerp_top import lkvl_pkg::*; #(
	parameter int unsigned MAX_KEYS = 64
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 req_valid,
	output logic                 req_stall,
	input  req_t                 req,
	output logic                 rsp_valid,
	input  logic                 rsp_stall,
	output rsp_t                 rsp,
	input  logic                 cfg_valid,
	output logic                 cfg_ready,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [31:0]          cfg_data
);

	cmd_t cmd;
	sts_t sts;

	assign cfg_ready = 1'b1;

	// sequencer
	lkvl_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_func  (req.func),
		.req_stall (req_stall),
		.sts       (sts),
		.cmd       (cmd)
	);

	// datapath
	lkvl_dp #(
		.MAX_KEYS (MAX_KEYS)
	) u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.req       (req),
		.cfg_valid (cfg_valid && cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.rsp_stall (rsp_stall),
		.rsp_valid (rsp_valid),
		.rsp       (rsp),
		.cmd       (cmd),
		.sts       (sts)
	);

endmodule

@@ rtl/lkvl_checker.sv @@
// ----------------------------------------------------------------------------
// lkvl_checker
// Port-level checks of the interpolator, bound to the top level
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module lkvl_checker import lkvl_pkg::*; (
	input logic clk,
	input logic arst_n,
	input logic req_valid,
	input logic req_stall,
	input req_t req,
	input logic rsp_valid,
	input logic rsp_stall,
	input rsp_t rsp
);

	logic sample_xfer;
	assign sample_xfer = req_valid && !req_stall && (req.func == FUNC_SAMPLE);

	// a stalled result stays offered
	`ASSERT_NEXT(a_rsp_hold, clk, arst_n, rsp_valid && rsp_stall, rsp_valid)
	// a stalled result keeps its payload
	`ASSERT_NEXT(a_rsp_stable, clk, arst_n, rsp_valid && rsp_stall, $stable(rsp))
	// a sample transfer makes the block busy
	`ASSERT_NEXT(a_busy, clk, arst_n, sample_xfer, req_stall)
	// a sample never finishes in the next cycle
	`ASSERT_NEXT(a_no_fast, clk, arst_n, sample_xfer, !$rose(rsp_valid))
	// blend fraction never exceeds one, and is zero on a bad span
	`ASSERT_IMPLY(a_frac, clk, arst_n, rsp_valid,
		(rsp.blend_frac <= ONE_Q16) && (!rsp.status || (rsp.blend_frac == '0)))

endmodule

bind looping_keyframe_vector_lerp_top lkvl_checker u_chk (.*);

@@ bench/testbench.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// testbench
// Checks the looping keyframe interpolator against a cycle-free predictor:
// a directed table of keyframe writes, samples and register writes, then
// random phases of sorted keyframe sets with samples, noise writes and
// several handshake idling patterns
// ----------------------------------------------------------------------------
module testbench;
	import lkvl_pkg::*;

	localparam int unsigned TABLE_DEPTH = 64;
	localparam int unsigned WATCHDOG_LIMIT = 5000;
	localparam int unsigned SETTLE_CYCLES = 60;
	localparam int unsigned RANDOM_ITEMS = 1600;

	typedef enum logic [1:0] {
		ROW_REQ,
		ROW_CFG
	} row_kind_t;

	typedef struct {
		row_kind_t   kind;
		req_t        item;
		logic [1:0]  cfg_idx;
		logic [31:0] cfg_val;
		bit          typed;
		rsp_t        typed_rsp;
	} stim_row_t;

	logic                 clk;
	logic                 arst_n;
	logic                 req_valid;
	logic                 req_stall;
	req_t                 req;
	logic                 rsp_valid;
	logic                 rsp_stall;
	rsp_t                 rsp;
	logic                 cfg_valid;
	logic                 cfg_ready;
	logic [CFG_IDX_W-1:0] cfg_index;
	logic [31:0]          cfg_data;

	// mirror of the block state
	logic [31:0] key_time_tab [TABLE_DEPTH];
	logic [31:0] key_val_tab [TABLE_DEPTH][3];
	logic [31:0] clip_len;
	logic [6:0]  key_cnt;

	rsp_t        pending_samples [$];
	int unsigned mismatches;
	int unsigned idle_mode;
	int unsigned quiet_cycles;
	stim_row_t   directed [$];

	looping_keyframe_vector_lerp_top dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_stall (req_stall),
		.req       (req),
		.rsp_valid (rsp_valid),
		.rsp_stall (rsp_stall),
		.rsp       (rsp),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	// clock
	initial begin
		clk = 1'b0;
		forever #6 clk = ~clk;
	end

	// interpolation of the clip at one play time
	function automatic rsp_t interpolate(logic [31:0] play);
		rsp_t        r;
		int unsigned n;
		int unsigned lo;
		int unsigned len;
		int unsigned half;
		int unsigned mid;
		int unsigned si;
		int unsigned ei;
		longint      ts;
		longint      te;
		longint      tp;
		longint      span;
		longint      target;
		longint      frac;
		longint      a;
		longint      b;
		longint      v[3];
		n = key_cnt;
		if (n == 0) n = 1;
		if (n > TABLE_DEPTH) n = TABLE_DEPTH;
		lo = 0;
		len = n;
		while (len > 0) begin
			half = len >> 1;
			mid = lo + half;
			if (key_time_tab[mid] <= play) begin
				lo = mid + 1;
				len = len - half - 1;
			end else begin
				len = half;
			end
		end
		if (lo == 0 || lo >= n) begin
			si = n - 1;
			ei = 0;
		end else begin
			si = lo - 1;
			ei = lo;
		end
		ts = longint'({32'd0, key_time_tab[si]});
		te = longint'({32'd0, key_time_tab[ei]});
		tp = longint'({32'd0, play});
		if (te < ts) begin
			span = (longint'({32'd0, clip_len}) - ts) + te;
			target = (tp < te) ? (longint'({32'd0, clip_len}) - ts) + tp : tp - ts;
		end else begin
			span = te - ts;
			target = tp - ts;
		end
		r.status = 1'b0;
		frac = 0;
		if (span <= 0) r.status = 1'b1;
		else if (target <= 0) frac = 0;
		else if (target >= span) frac = 65536;
		else frac = (target <<< 16) / span;
		for (int c = 0; c < 3; c++) begin
			a = longint'(signed'(key_val_tab[si][c]));
			b = longint'(signed'(key_val_tab[ei][c]));
			v[c] = r.status ? a : a + (((b - a) * frac) >>> 16);
		end
		r.value_x = v[0][31:0];
		r.value_y = v[1][31:0];
		r.value_z = v[2][31:0];
		r.blend_frac = frac[16:0];
		return r;
	endfunction

	// sender gap according to the idling pattern
	function automatic bit sender_idles();
		case (idle_mode)
			1: return $urandom_range(99) < 84;
			3: return $urandom_range(99) < 10;
			default: return 1'b0;
		endcase
	endfunction

	// one input transfer; updates the mirror or queues the expected result
	task automatic send_item(req_t item, bit typed, rsp_t typed_rsp);
		if (sender_idles()) begin
			req_valid <= 1'b0;
			@(posedge clk);
			while (sender_idles()) @(posedge clk);
		end
		req_valid <= 1'b1;
		req <= item;
		do @(posedge clk); while (req_stall);
		if (item.func == FUNC_WRITE) begin
			key_time_tab[item.key_index] = item.key_time;
			key_val_tab[item.key_index][0] = item.key_x;
			key_val_tab[item.key_index][1] = item.key_y;
			key_val_tab[item.key_index][2] = item.key_z;
		end else begin
			pending_samples.push_back(typed ? typed_rsp : interpolate(item.play_time));
		end
	endtask

	// register write, only once the block has gone quiet
	task automatic write_reg(logic [1:0] idx, logic [31:0] val);
		req_valid <= 1'b0;
		wait (pending_samples.size() == 0);
		repeat (SETTLE_CYCLES) @(posedge clk);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		do @(posedge clk); while (!cfg_ready);
		cfg_valid <= 1'b0;
		if (idx == CFG_CLIP_LENGTH) clip_len = val;
		else if (idx == CFG_KEY_COUNT) key_cnt = val[6:0];
	endtask

	function automatic req_t key_write(logic [5:0] slot, logic [31:0] t,
			logic [31:0] x, logic [31:0] y, logic [31:0] z);
		req_t r;
		r.func = FUNC_WRITE;
		r.key_index = slot;
		r.key_time = t;
		r.key_x = x;
		r.key_y = y;
		r.key_z = z;
		r.play_time = $urandom;
		return r;
	endfunction

	function automatic req_t sample_at(logic [31:0] play);
		req_t r;
		r = key_write(6'($urandom), $urandom, $urandom, $urandom, $urandom);
		r.func = FUNC_SAMPLE;
		r.play_time = play;
		return r;
	endfunction

	function automatic rsp_t held(logic [31:0] x, logic [31:0] y, logic [31:0] z,
			logic st);
		rsp_t r;
		r.value_x = x;
		r.value_y = y;
		r.value_z = z;
		r.blend_frac = '0;
		r.status = st;
		return r;
	endfunction

	task automatic add_req(req_t item);
		directed.push_back('{ROW_REQ, item, 2'd0, 32'd0, 1'b0, '0});
	endtask

	task automatic add_typed(req_t item, rsp_t r);
		directed.push_back('{ROW_REQ, item, 2'd0, 32'd0, 1'b1, r});
	endtask

	task automatic add_cfg(logic [1:0] idx, logic [31:0] val);
		directed.push_back('{ROW_CFG, '0, idx, val, 1'b0, '0});
	endtask

	// receiver stalls
	always @(posedge clk) begin
		case (idle_mode)
			2: rsp_stall <= $urandom_range(99) < 84;
			3: rsp_stall <= $urandom_range(99) < 10;
			default: rsp_stall <= 1'b0;
		endcase
	end

	// result check against the oldest expectation
	always @(posedge clk) begin
		rsp_t want;
		if (arst_n && rsp_valid && !rsp_stall) begin
			if (pending_samples.size() == 0) begin
				mismatches++;
				if (mismatches <= 10) $display("unexpected result %h", rsp);
			end else begin
				want = pending_samples.pop_front();
				if (rsp !== want) begin
					mismatches++;
					if (mismatches <= 10)
						$display("result mismatch: x %h/%h y %h/%h z %h/%h frac %h/%h st %b/%b",
							want.value_x, rsp.value_x, want.value_y, rsp.value_y,
							want.value_z, rsp.value_z, want.blend_frac, rsp.blend_frac,
							want.status, rsp.status);
				end
			end
		end
	end

	// watchdog on cycles without any transfer
	always @(posedge clk) begin
		if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall) || (cfg_valid && cfg_ready))
			quiet_cycles <= 0;
		else
			quiet_cycles <= quiet_cycles + 1;
		if (quiet_cycles >= WATCHDOG_LIMIT) begin
			$display("watchdog expired");
			$display("== FAIL ==");
			$finish;
		end
	end

	// stimulus
	initial begin
		int unsigned issued;
		int unsigned n;
		int unsigned cfg_raw;
		int unsigned phase;
		int unsigned span_bits;
		logic [31:0] times [$];
		logic [31:0] last_t;
		logic [31:0] play;
		req_t        item;
		arst_n = 1'b0;
		req_valid = 1'b0;
		req = '0;
		rsp_stall = 1'b0;
		cfg_valid = 1'b0;
		cfg_index = '0;
		cfg_data = '0;
		idle_mode = 0;
		quiet_cycles = 0;
		mismatches = 0;
		clip_len = '0;
		key_cnt = 7'd1;
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed table: reset values, extremes, wrap, negative and zero span
		add_req(key_write(6'd0, 32'h100, 32'h7FFFFFFF, 32'h80000000, 32'h0));
		add_typed(sample_at(32'h0), held(32'h7FFFFFFF, 32'h80000000, 32'h0, 1'b1));
		add_typed(sample_at(32'hFFFFFFFF), held(32'h7FFFFFFF, 32'h80000000, 32'h0, 1'b1));
		add_req(key_write(6'd63, 32'hFFFFFFFF, 32'hFFFFFFFF, 32'h1, 32'h7FFFFFFF));
		add_req(key_write(6'd1, 32'h300, 32'h80000000, 32'h7FFFFFFF, 32'hFFFF0000));
		add_cfg(CFG_KEY_COUNT, 32'd2);
		add_cfg(CFG_CLIP_LENGTH, 32'h400);
		add_typed(sample_at(32'h100), held(32'h7FFFFFFF, 32'h80000000, 32'h0, 1'b0));
		add_req(sample_at(32'h200));
		add_req(sample_at(32'h2FF));
		add_req(sample_at(32'h300));
		add_req(sample_at(32'h380));
		add_req(sample_at(32'h50));
		add_cfg(CFG_CLIP_LENGTH, 32'h100);
		add_typed(sample_at(32'h350), held(32'h80000000, 32'h7FFFFFFF, 32'hFFFF0000, 1'b1));
		add_req(key_write(6'd1, 32'h100, 32'h12345, 32'hFFFEDCBA, 32'h0));
		add_typed(sample_at(32'h100), held(32'h12345, 32'hFFFEDCBA, 32'h0, 1'b1));
		add_cfg(2'd3, 32'hFFFFFFFF);
		add_cfg(CFG_KEY_COUNT, 32'd0);
		add_typed(sample_at(32'h5), held(32'h7FFFFFFF, 32'h80000000, 32'h0, 1'b1));
		add_cfg(CFG_CLIP_LENGTH, 32'hFFFFFFFF);
		add_req(sample_at(32'h80000000));
		foreach (directed[i]) begin
			if (directed[i].kind == ROW_CFG)
				write_reg(directed[i].cfg_idx, directed[i].cfg_val);
			else
				send_item(directed[i].item, directed[i].typed, directed[i].typed_rsp);
		end

		// random phases: a sorted key set, then samples with some noise writes
		issued = 0;
		phase = 0;
		while (issued < RANDOM_ITEMS) begin
			idle_mode = phase % 4;
			case (phase % 8)
				0: cfg_raw = 127;
				1: cfg_raw = 64;
				2: cfg_raw = 0;
				3: cfg_raw = 1;
				default: cfg_raw = $urandom_range(127);
			endcase
			write_reg(CFG_KEY_COUNT, {25'($urandom_range(32'h1FFFFFF)), cfg_raw[6:0]});
			if ($urandom_range(3) == 0) write_reg(2'd2, $urandom);
			n = (cfg_raw == 0) ? 1 : (cfg_raw > TABLE_DEPTH ? TABLE_DEPTH : cfg_raw);
			span_bits = ($urandom_range(3) == 0) ? 4 : 32;
			times.delete();
			for (int i = 0; i < n; i++)
				times.push_back(span_bits == 32 ? $urandom : $urandom_range(15) + 32'h8000);
			times.sort();
			last_t = times[n - 1];
			case ($urandom_range(4))
				0: write_reg(CFG_CLIP_LENGTH, 32'h0);
				1: write_reg(CFG_CLIP_LENGTH, 32'hFFFFFFFF);
				2: write_reg(CFG_CLIP_LENGTH, last_t - $urandom_range(255));
				3: write_reg(CFG_CLIP_LENGTH, last_t + $urandom_range(32'hFFFF));
				default: write_reg(CFG_CLIP_LENGTH, $urandom);
			endcase
			for (int i = 0; i < n; i++) begin
				send_item(key_write(6'(i), times[i], $urandom, $urandom, $urandom), 1'b0, '0);
				issued++;
			end
			for (int k = 0; k < 90; k++) begin
				case ($urandom_range(9))
					0: item = key_write(6'($urandom), $urandom, $urandom, $urandom, $urandom);
					1: item = sample_at($urandom);
					2, 3: item = sample_at(times[$urandom_range(n - 1)]);
					4: item = sample_at(last_t + $urandom_range(255));
					5: item = sample_at(times[0] - $urandom_range(255));
					default: begin
						play = times[$urandom_range(n - 1)];
						item = sample_at(play + $urandom_range(32'hFFFF) - 32'h7FFF);
					end
				endcase
				send_item(item, 1'b0, '0);
				issued++;
			end
			phase++;
		end

		req_valid <= 1'b0;
		wait (pending_samples.size() == 0);
		repeat (SETTLE_CYCLES) @(posedge clk);
		if (mismatches == 0)
			$display("== PASS ==");
		else
			$display("== FAIL ==");
		$finish;
	end

endmodule
